// ===== hw/rtl/uri_component_splitter_top_assert.svh =====
// Assertion macros shared by the splitter RTL modules.
`ifndef URI_COMPONENT_SPLITTER_TOP_ASSERT_SVH
`define URI_COMPONENT_SPLITTER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define USC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define USC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define USC_ASSERT_IMPL(label, ante, cons, msg)
`define USC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/usc_pkg.sv =====
// Shared types and constants of the URI component splitter.
`default_nettype none
package usc_pkg;

    typedef enum logic [2:0] {
        PART_SCHEME    = 3'd0,
        PART_AUTHORITY = 3'd1,
        PART_PATH      = 3'd2,
        PART_QUERY     = 3'd3,
        PART_FRAGMENT  = 3'd4
    } part_t;

    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_QUEST = 8'h3F;
    localparam logic [7:0] CHR_HASH  = 8'h23;

    // Result slots of one item, emitted from low bit to high bit.
    localparam int SLOT_PRE_COLON  = 0;
    localparam int SLOT_PRE_SLASH  = 1;
    localparam int SLOT_BYTE       = 2;
    localparam int SLOT_TAIL_COLON = 3;
    localparam int SLOT_TAIL_SLASH = 4;
    localparam int SLOT_END        = 5;
    localparam int NUM_SLOTS       = 6;

    localparam int USC_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [7:0]           text;
        part_t                part;
        logic                 miss;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_head_t;

endpackage
`default_nettype wire

// ===== hw/rtl/usc_front.sv =====
// Front end: tracks the current component and turns each byte into a result descriptor.
`default_nettype none
`include "uri_component_splitter_top_assert.svh"
module usc_front
    import usc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    input  wire logic       final_byte,
    output desc_t           desc,
    output logic            desc_push
);

    part_t      part_reg, part_next;
    logic [1:0] dm_reg, dm_next;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    always_comb
    begin
        part_next = part_reg;
        dm_next   = dm_reg;
        desc      = '0;
        desc.text = text_byte;
        desc.part = part_reg;
        case (part_reg)
            PART_SCHEME:
            begin
                if (dm_reg == 2'd2 && text_byte == CHR_SLASH)
                begin
                    part_next = PART_AUTHORITY;
                    dm_next   = 2'd0;
                end
                else if (dm_reg == 2'd1 && text_byte == CHR_SLASH)
                begin
                    dm_next = 2'd2;
                end
                else
                begin
                    // release the held partial match ahead of this byte
                    desc.slot_mask[SLOT_PRE_COLON] = |dm_reg;
                    desc.slot_mask[SLOT_PRE_SLASH] = dm_reg[1];
                    if (text_byte == CHR_COLON)
                    begin
                        dm_next = 2'd1;
                    end
                    else
                    begin
                        dm_next                   = 2'd0;
                        desc.slot_mask[SLOT_BYTE] = 1'b1;
                        desc.text                 = to_lower(text_byte);
                    end
                end
            end
            PART_AUTHORITY:
            begin
                desc.slot_mask[SLOT_BYTE] = 1'b1;
                if (text_byte == CHR_SLASH)
                begin
                    part_next = PART_PATH;
                    desc.part = PART_PATH;
                end
                else
                begin
                    desc.text = to_lower(text_byte);
                end
            end
            PART_PATH:
            begin
                if (text_byte == CHR_QUEST)
                begin
                    part_next = PART_QUERY;
                end
                else
                begin
                    desc.slot_mask[SLOT_BYTE] = 1'b1;
                end
            end
            PART_QUERY:
            begin
                if (text_byte == CHR_HASH)
                begin
                    part_next = PART_FRAGMENT;
                end
                else
                begin
                    desc.slot_mask[SLOT_BYTE] = 1'b1;
                end
            end
            default:
            begin
                desc.part                 = PART_FRAGMENT;
                desc.slot_mask[SLOT_BYTE] = 1'b1;
            end
        endcase

        if (final_byte)
        begin
            if (part_next == PART_SCHEME)
            begin
                desc.slot_mask[SLOT_TAIL_COLON] = |dm_next;
                desc.slot_mask[SLOT_TAIL_SLASH] = dm_next[1];
                desc.miss                       = 1'b1;
            end
            desc.slot_mask[SLOT_END] = 1'b1;
        end
    end

    assign desc_push = accept && (|desc.slot_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= PART_SCHEME;
            dm_reg   <= 2'd0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                part_reg <= PART_SCHEME;
                dm_reg   <= 2'd0;
            end
            else
            begin
                part_reg <= part_next;
                dm_reg   <= dm_next;
            end
        end
    end

    `USC_ASSERT_NEXT(a_final_resets, accept && final_byte, part_reg == PART_SCHEME && dm_reg == 2'd0, "state not reset after final byte")
    `USC_ASSERT_IMPL(a_match_only_in_scheme, dm_reg != 2'd0, part_reg == PART_SCHEME && dm_reg != 2'd3, "delimiter match held outside scheme")

endmodule
`default_nettype wire

// ===== hw/rtl/usc_queue.sv =====
// Descriptor queue between the front end and the result sequencer.
`default_nettype none
`include "uri_component_splitter_top_assert.svh"
module usc_queue
    import usc_pkg::*;
#(
    parameter int DEPTH = USC_QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire desc_t wr_data,
    input  wire logic  rd_en,
    output q_head_t    head,
    output logic       full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_rd;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.desc  = mem_reg[rd_ptr_reg];
    assign do_rd      = rd_en && head.valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `USC_ASSERT_IMPL(a_no_overflow, full, !wr_en || do_rd, "write into full queue")
    `USC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule
`default_nettype wire

// ===== hw/rtl/usc_back.sv =====
// Back end: expands each descriptor into result transactions and holds the output register.
`default_nettype none
`include "uri_component_splitter_top_assert.svh"
module usc_back
    import usc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire q_head_t     head,
    output logic             head_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic [2:0]       part_code,
    output logic             byte_valid,
    output logic             uri_end,
    output logic             missing_delimiter
);

    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] pick;
    logic                 item_done;
    logic                 advance;
    logic                 out_valid_reg;
    logic                 pop_fire;

    logic [7:0] byte_next;
    logic [2:0] part_next;
    logic       valid_next;
    logic       end_next;
    logic       miss_next;

    logic [7:0] byte_reg;
    logic [2:0] part_reg;
    logic       valid_reg;
    logic       end_reg;
    logic       miss_reg;

    assign remaining = head.desc.slot_mask & ~done_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign item_done = ((remaining & ~pick) == '0);
    assign pop_fire  = pop && out_valid_reg;
    assign advance   = head.valid && (!out_valid_reg || pop_fire);
    assign head_pop  = advance && item_done;

    always_comb
    begin
        byte_next  = 8'd0;
        part_next  = PART_SCHEME;
        valid_next = 1'b1;
        end_next   = 1'b0;
        miss_next  = 1'b0;
        if (pick[SLOT_PRE_COLON] || pick[SLOT_TAIL_COLON])
        begin
            byte_next = CHR_COLON;
        end
        else if (pick[SLOT_PRE_SLASH] || pick[SLOT_TAIL_SLASH])
        begin
            byte_next = CHR_SLASH;
        end
        else if (pick[SLOT_BYTE])
        begin
            byte_next = head.desc.text;
            part_next = head.desc.part;
        end
        else
        begin
            valid_next = 1'b0;
            end_next   = 1'b1;
            miss_next  = head.desc.miss;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                done_reg      <= item_done ? '0 : (done_reg | pick);
                out_valid_reg <= 1'b1;
            end
            else if (pop_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg  <= byte_next;
            part_reg  <= part_next;
            valid_reg <= valid_next;
            end_reg   <= end_next;
            miss_reg  <= miss_next;
        end
    end

    assign empty             = !out_valid_reg;
    assign out_byte          = byte_reg;
    assign part_code         = part_reg;
    assign byte_valid        = valid_reg;
    assign uri_end           = end_reg;
    assign missing_delimiter = miss_reg;

    `USC_ASSERT_IMPL(a_head_not_empty, head.valid, remaining != '0, "queued descriptor has no result left")
    `USC_ASSERT_NEXT(a_hold_stalled, out_valid_reg && !pop, out_valid_reg && $stable(byte_reg) && $stable(end_reg), "stalled result changed")

endmodule
`default_nettype wire

// ===== hw/rtl/uri_component_splitter_top.sv =====
// Top level of the URI component splitter: front end, descriptor queue and result sequencer.
// Input: one byte per cycle when not full; full rises only at QUEUE_DEPTH queued descriptors.
// An accepted byte's results are written to the descriptor queue, then loaded into the output
// register; they show later when results of earlier bytes are still waiting.
// Throughput: one result per cycle while the consumer pops; a byte yields zero to four results.
// Reset: rst_n clears component state, queue pointers and output valid at once, asynchronously.
`default_nettype none
module uri_component_splitter_top
    import usc_pkg::*;
#(
    parameter int QUEUE_DEPTH = USC_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] text_byte,
    input  wire logic       final_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic [2:0]      part_code,
    output logic            byte_valid,
    output logic            uri_end,
    output logic            missing_delimiter
);

    // An input transaction completes on push while the queue has room.
    logic    accept;
    desc_t   desc;
    logic    desc_push;
    q_head_t head;
    logic    head_pop;

    assign accept = push && !full;

    // Classify the byte and build the list of results it causes; items with no
    // result (dropped delimiters) never enter the queue.
    usc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .desc       (desc),
        .desc_push  (desc_push)
    );

    // Decouple the byte stream from result delivery so a multi-result byte or a
    // stalled consumer does not stop intake right away.
    usc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc),
        .rd_en   (head_pop),
        .head    (head),
        .full    (full)
    );

    // Walk the slots of the head descriptor, one result transaction per cycle unless stalled,
    // through an output register that reloads in the same cycle it is popped.
    usc_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .head_pop          (head_pop),
        .pop               (pop),
        .empty             (empty),
        .out_byte          (out_byte),
        .part_code         (part_code),
        .byte_valid        (byte_valid),
        .uri_end           (uri_end),
        .missing_delimiter (missing_delimiter)
    );

endmodule
`default_nettype wire

// ===== verif/tb_uri_component_splitter_top.sv =====
// Self-checking testbench for the URI component splitter top level.
`timescale 1ns / 1ps

module tb_uri_component_splitter_top
    import usc_pkg::*;
;

    // One tagged output transaction, laid out as the result ports.
    typedef struct packed {
        logic [7:0] ob;
        logic [2:0] part;
        logic       vld;
        logic       endf;
        logic       miss;
    } tag_t;

    // One input byte. Directed rows may carry the tags typed in by hand;
    // all other rows take their tags from the splitter predictor.
    typedef struct packed {
        logic [7:0]       txt;
        logic             fin;
        logic             typed_en;
        logic [1:0]       n_typed;
        tag_t [1:0]       typed;
    } uri_byte_t;

    localparam int DIR_N       = 24;     // rows of the directed table
    localparam int RAND_ITEMS  = 86;     // random bytes after the table
    localparam int IDLE_PCT    = 19;     // idle cycles per hundred, each side
    localparam int CALM_FROM   = 150;    // window with no idling at all
    localparam int CALM_TO     = 300;
    localparam int STALL_AT    = 50;     // receiver holds off from this cycle
    localparam int STALL_LEN   = 80;     // ... for this many cycles
    localparam int DRAIN       = 8;      // extra cycles after the last tag
    localparam int LIMIT_NS    = 2_000_000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       final_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic [2:0] part_code;
    logic       byte_valid;
    logic       uri_end;
    logic       missing_delimiter;

    // Predictor state: component being filled and held part of "://".
    part_t      cur_part;
    logic [1:0] held;

    uri_byte_t  uri_bytes_q[$];
    tag_t       tagged_bytes_q[$];
    uri_byte_t  dir_tab[DIR_N];
    tag_t       want;
    int         mismatch_cnt = 0;
    int         cyc = 0;
    logic       calm;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    uri_component_splitter_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .text_byte         (text_byte),
        .final_byte        (final_byte),
        .empty             (empty),
        .pop               (pop),
        .out_byte          (out_byte),
        .part_code         (part_code),
        .byte_valid        (byte_valid),
        .uri_end           (uri_end),
        .missing_delimiter (missing_delimiter)
    );

    // 12 ns clock: low half, then high half.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold reset at the start, then release it for good.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog: end the run if the tags never drain.
    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic tag_t mk_tag(input logic [7:0] b, input part_t p, input logic v,
                                    input logic e, input logic m);
        tag_t t;
        t.ob   = b;
        t.part = p;
        t.vld  = v;
        t.endf = e;
        t.miss = m;
        return t;
    endfunction

    function automatic uri_byte_t row(input logic [7:0] b, input logic f, input logic te,
                                      input int n, input tag_t t0, input tag_t t1);
        uri_byte_t r;
        r.txt      = b;
        r.fin      = f;
        r.typed_en = te;
        r.n_typed  = n[1:0];
        r.typed[0] = t0;
        r.typed[1] = t1;
        return r;
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
            return 8'h41 + 8'($urandom_range(25));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    // Bias random text toward the delimiters so that every component is reached.
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
        begin
            case ($urandom_range(3))
                0: return CHR_COLON;
                1: return CHR_SLASH;
                2: return CHR_QUEST;
                default: return CHR_HASH;
            endcase
        end
        if (sel < 75)
            return rand_letter();
        return 8'($urandom_range(255));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        uri_bytes_q.push_back(row(b, 1'b0, 1'b0, 0, '0, '0));
    endtask

    // Mark the last queued byte as the end of its URI.
    task automatic close_uri();
        uri_byte_t r;
        r = uri_bytes_q.pop_back();
        r.fin = 1'b1;
        uri_bytes_q.push_back(r);
    endtask

    // Splitter predictor: tag one byte, advance the component state,
    // and return up to four output transactions.
    task automatic split_byte(input logic [7:0] b, input logic fin,
                              output int n, output tag_t [3:0] tags);
        logic miss;
        n = 0;
        tags = '0;
        case (cur_part)
            PART_SCHEME:
            begin
                if (held == 2'd2 && b == CHR_SLASH)
                begin
                    held = 2'd0;
                    cur_part = PART_AUTHORITY;
                end
                else if (held == 2'd1 && b == CHR_SLASH)
                    held = 2'd2;
                else
                begin
                    // Release a broken partial "://" ahead of this byte.
                    if (held >= 2'd1)
                    begin
                        tags[n] = mk_tag(CHR_COLON, PART_SCHEME, 1'b1, 1'b0, 1'b0);
                        n = n + 1;
                    end
                    if (held >= 2'd2)
                    begin
                        tags[n] = mk_tag(CHR_SLASH, PART_SCHEME, 1'b1, 1'b0, 1'b0);
                        n = n + 1;
                    end
                    if (b == CHR_COLON)
                        held = 2'd1;
                    else
                    begin
                        held = 2'd0;
                        tags[n] = mk_tag(lower_ascii(b), PART_SCHEME, 1'b1, 1'b0, 1'b0);
                        n = n + 1;
                    end
                end
            end
            PART_AUTHORITY:
            begin
                if (b == CHR_SLASH)
                begin
                    cur_part = PART_PATH;
                    tags[n] = mk_tag(b, PART_PATH, 1'b1, 1'b0, 1'b0);
                end
                else
                    tags[n] = mk_tag(lower_ascii(b), PART_AUTHORITY, 1'b1, 1'b0, 1'b0);
                n = n + 1;
            end
            PART_PATH:
            begin
                // A '#' before any '?' stays in the path.
                if (b == CHR_QUEST)
                    cur_part = PART_QUERY;
                else
                begin
                    tags[n] = mk_tag(b, PART_PATH, 1'b1, 1'b0, 1'b0);
                    n = n + 1;
                end
            end
            PART_QUERY:
            begin
                if (b == CHR_HASH)
                    cur_part = PART_FRAGMENT;
                else
                begin
                    tags[n] = mk_tag(b, PART_QUERY, 1'b1, 1'b0, 1'b0);
                    n = n + 1;
                end
            end
            default:
            begin
                tags[n] = mk_tag(b, PART_FRAGMENT, 1'b1, 1'b0, 1'b0);
                n = n + 1;
            end
        endcase

        if (fin)
        begin
            // Flush held delimiter bytes, then close the URI.
            miss = (cur_part == PART_SCHEME);
            if (miss && held >= 2'd1)
            begin
                tags[n] = mk_tag(CHR_COLON, PART_SCHEME, 1'b1, 1'b0, 1'b0);
                n = n + 1;
            end
            if (miss && held >= 2'd2)
            begin
                tags[n] = mk_tag(CHR_SLASH, PART_SCHEME, 1'b1, 1'b0, 1'b0);
                n = n + 1;
            end
            tags[n] = mk_tag(8'h00, PART_SCHEME, 1'b0, 1'b1, miss);
            n = n + 1;
            cur_part = PART_SCHEME;
            held = 2'd0;
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 exp_val);
        mismatch_cnt = mismatch_cnt + 1;
    endtask

    // Sender: build the stimulus, push it byte by byte, predict on acceptance,
    // then drain and report.
    initial
    begin : sender
        uri_byte_t  cur;
        tag_t [3:0] got;
        int         n;
        int         k;
        int         idx;
        int         len;

        push       = 1'b0;
        text_byte  = 8'h00;
        final_byte = 1'b0;
        cur_part   = PART_SCHEME;
        held       = 2'd0;

        // Directed table. Tags typed in where obvious; rows with typed_en clear use the predictor.
        dir_tab[0]  = row(8'h48, 1'b0, 1'b1, 1,                  // 'H' after reset, lowercased
                          mk_tag(8'h68, PART_SCHEME, 1'b1, 1'b0, 1'b0), '0);
        dir_tab[1]  = row(8'hFF, 1'b0, 1'b1, 1,                  // top byte value
                          mk_tag(8'hFF, PART_SCHEME, 1'b1, 1'b0, 1'b0), '0);
        dir_tab[2]  = row(CHR_COLON, 1'b0, 1'b1, 0, '0, '0);     // held, nothing out
        dir_tab[3]  = row(8'h78, 1'b0, 1'b0, 0, '0, '0);         // releases ':' then 'x'
        dir_tab[4]  = row(CHR_COLON, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[5]  = row(CHR_SLASH, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[6]  = row(CHR_COLON, 1'b0, 1'b0, 0, '0, '0);     // breaks ":/", restarts
        dir_tab[7]  = row(CHR_SLASH, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[8]  = row(CHR_SLASH, 1'b0, 1'b0, 0, '0, '0);     // "://" complete
        dir_tab[9]  = row(8'h45, 1'b0, 1'b0, 0, '0, '0);         // authority, lowercased
        dir_tab[10] = row(8'h78, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[11] = row(CHR_SLASH, 1'b0, 1'b0, 0, '0, '0);     // path opens, kept
        dir_tab[12] = row(CHR_HASH, 1'b0, 1'b0, 0, '0, '0);      // hash stays in path
        dir_tab[13] = row(CHR_QUEST, 1'b0, 1'b0, 0, '0, '0);     // query opens, dropped
        dir_tab[14] = row(CHR_QUEST, 1'b0, 1'b0, 0, '0, '0);     // later '?' is plain
        dir_tab[15] = row(CHR_HASH, 1'b0, 1'b0, 0, '0, '0);      // fragment opens
        dir_tab[16] = row(CHR_HASH, 1'b0, 1'b0, 0, '0, '0);      // later '#' is plain
        dir_tab[17] = row(8'h00, 1'b1, 1'b1, 2,                  // bottom byte, close
                          mk_tag(8'h00, PART_FRAGMENT, 1'b1, 1'b0, 1'b0),
                          mk_tag(8'h00, PART_SCHEME, 1'b0, 1'b1, 1'b0));
        dir_tab[18] = row(8'h61, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[19] = row(CHR_COLON, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[20] = row(CHR_SLASH, 1'b0, 1'b0, 0, '0, '0);
        dir_tab[21] = row(CHR_COLON, 1'b1, 1'b0, 0, '0, '0);     // four tags at once
        dir_tab[22] = row(8'h00, 1'b1, 1'b1, 2,                  // lone byte, no delimiter
                          mk_tag(8'h00, PART_SCHEME, 1'b1, 1'b0, 1'b0),
                          mk_tag(8'h00, PART_SCHEME, 1'b0, 1'b1, 1'b1));
        dir_tab[23] = row(CHR_SLASH, 1'b1, 1'b0, 0, '0, '0);     // '/' in scheme
        for (k = 0; k < DIR_N; k++)
            uri_bytes_q.push_back(dir_tab[k]);

        // Random part: mostly well-formed URIs with random content, some noise.
        while (uri_bytes_q.size() < DIR_N + RAND_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++)
                    add_byte(($urandom_range(9) == 0) ? CHR_COLON : rand_letter());
                if ($urandom_range(9) != 0)
                begin
                    add_byte(CHR_COLON);
                    add_byte(CHR_SLASH);
                    add_byte(CHR_SLASH);
                end
                else
                begin
                    // Broken delimiter.
                    add_byte(CHR_COLON);
                    if ($urandom_range(1) == 1)
                        add_byte(CHR_SLASH);
                    add_byte(rand_letter());
                end
                len = $urandom_range(4);
                for (k = 0; k < len; k++)
                    add_byte(pick_char());
                if ($urandom_range(1) == 1)
                begin
                    add_byte(CHR_SLASH);
                    len = $urandom_range(3);
                    for (k = 0; k < len; k++)
                        add_byte(pick_char());
                end
                if ($urandom_range(99) < 40)
                begin
                    add_byte(CHR_QUEST);
                    len = $urandom_range(3);
                    for (k = 0; k < len; k++)
                        add_byte(pick_char());
                end
                if ($urandom_range(99) < 30)
                begin
                    add_byte(CHR_HASH);
                    len = $urandom_range(3);
                    for (k = 0; k < len; k++)
                        add_byte(pick_char());
                end
            end
            else
            begin
                len = $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                    add_byte(pick_char());
            end
            close_uri();
        end

        wait (rst_n === 1'b1);
        idx = 0;
        while (idx < uri_bytes_q.size())
        begin
            // Drive at the falling edge; idle now and then with junk on the bus.
            @(negedge clk);
            cur = uri_bytes_q[idx];
            if (!calm && $urandom_range(99) < IDLE_PCT)
            begin
                push       <= 1'b0;
                text_byte  <= 8'($urandom);
                final_byte <= 1'($urandom);
            end
            else
            begin
                push       <= 1'b1;
                text_byte  <= cur.txt;
                final_byte <= cur.fin;
            end
            // Sample the handshake at the rising edge; predict on acceptance.
            @(posedge clk);
            if (push && !full)
            begin
                split_byte(cur.txt, cur.fin, n, got);
                if (cur.typed_en)
                begin
                    for (k = 0; k < cur.n_typed; k++)
                        tagged_bytes_q.push_back(cur.typed[k]);
                end
                else
                begin
                    for (k = 0; k < n; k++)
                        tagged_bytes_q.push_back(got[k]);
                end
                idx = idx + 1;
            end
        end
        @(negedge clk);
        push <= 1'b0;

        // Wait for every expected tag, then let the pipeline settle.
        while (tagged_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: pop at random, with one long hold-off to fill the block
    // and push back on the sender.
    initial
    begin : receiver
        int stall_cnt;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (cyc == STALL_AT)
            begin
                pop <= 1'b0;
                stall_cnt = 0;
                while (stall_cnt < STALL_LEN)
                begin
                    @(negedge clk);
                    stall_cnt = stall_cnt + 1;
                end
            end
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Output checker: compare each popped transaction with the oldest tag.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc = cyc + 1;
            if (pop && !empty)
            begin
                if (tagged_bytes_q.size() == 0)
                    flag_mismatch("transaction with nothing expected", int'(out_byte), 0);
                else
                begin
                    want = tagged_bytes_q.pop_front();
                    if (out_byte !== want.ob)
                        flag_mismatch("out_byte", int'(out_byte), int'(want.ob));
                    if (part_code !== want.part)
                        flag_mismatch("part_code", int'(part_code), int'(want.part));
                    if (byte_valid !== want.vld)
                        flag_mismatch("byte_valid", int'(byte_valid), int'(want.vld));
                    if (uri_end !== want.endf)
                        flag_mismatch("uri_end", int'(uri_end), int'(want.endf));
                    if (missing_delimiter !== want.miss)
                        flag_mismatch("missing_delimiter", int'(missing_delimiter),
                                      int'(want.miss));
                end
            end
        end
    end

endmodule
